// ===== rtl/tsfe_pkg.sv =====
package tsfe_pkg;

	// function select codes
	localparam logic [2:0] CMD_SIN   = 3'd0;
	localparam logic [2:0] CMD_COS   = 3'd1;
	localparam logic [2:0] CMD_EXP   = 3'd2;
	localparam logic [2:0] CMD_LOG1P = 3'd3;
	localparam logic [2:0] CMD_ATAN  = 3'd4;

	// register map: register index is paddr above the byte offset
	localparam int unsigned APB_AW = 3;
	localparam logic [APB_AW-3:0] REG_MAX_POWER = 1'b0;
	localparam logic [3:0] MAX_POWER_RST = 4'd7;

	// magnitude limit for powers, terms and the running sum
	localparam logic [62:0] MAG_LIMIT = 63'h4000_0000_0000_0000;
	localparam logic signed [64:0] ACC_LIM_P = 65'sh0_4000_0000_0000_0000;
	localparam logic signed [64:0] ACC_LIM_N = -ACC_LIM_P;

	// result range, Q10.x in 40 bits
	localparam logic signed [63:0] OUT_MAX = 64'sh0000_007F_FFFF_FFFF;
	localparam logic signed [63:0] OUT_MIN = 64'shFFFF_FF80_0000_0000;

	// coefficient tables, unsigned Q1.63, round to nearest
	localparam int unsigned COEF_N = 32;
	localparam logic [63:0] TWO63 = 64'h8000_0000_0000_0000;

	localparam logic [63:0] INV_FACT [COEF_N] = '{
		(TWO63 + 64'd1 / 64'd2) / 64'd1,
		(TWO63 + 64'd1 / 64'd2) / 64'd1,
		(TWO63 + 64'd2 / 64'd2) / 64'd2,
		(TWO63 + 64'd6 / 64'd2) / 64'd6,
		(TWO63 + 64'd24 / 64'd2) / 64'd24,
		(TWO63 + 64'd120 / 64'd2) / 64'd120,
		(TWO63 + 64'd720 / 64'd2) / 64'd720,
		(TWO63 + 64'd5040 / 64'd2) / 64'd5040,
		(TWO63 + 64'd40320 / 64'd2) / 64'd40320,
		(TWO63 + 64'd362880 / 64'd2) / 64'd362880,
		(TWO63 + 64'd3628800 / 64'd2) / 64'd3628800,
		(TWO63 + 64'd39916800 / 64'd2) / 64'd39916800,
		(TWO63 + 64'd479001600 / 64'd2) / 64'd479001600,
		(TWO63 + 64'd6227020800 / 64'd2) / 64'd6227020800,
		(TWO63 + 64'd87178291200 / 64'd2) / 64'd87178291200,
		(TWO63 + 64'd1307674368000 / 64'd2) / 64'd1307674368000,
		(TWO63 + 64'd20922789888000 / 64'd2) / 64'd20922789888000,
		(TWO63 + 64'd355687428096000 / 64'd2) / 64'd355687428096000,
		(TWO63 + 64'd6402373705728000 / 64'd2) / 64'd6402373705728000,
		(TWO63 + 64'd121645100408832000 / 64'd2) / 64'd121645100408832000,
		(TWO63 + 64'd2432902008176640000 / 64'd2) / 64'd2432902008176640000,
		64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
	};

	localparam logic [63:0] RECIP_N [COEF_N] = '{
		64'd0,
		(TWO63 + 64'd1 / 64'd2) / 64'd1,
		(TWO63 + 64'd2 / 64'd2) / 64'd2,
		(TWO63 + 64'd3 / 64'd2) / 64'd3,
		(TWO63 + 64'd4 / 64'd2) / 64'd4,
		(TWO63 + 64'd5 / 64'd2) / 64'd5,
		(TWO63 + 64'd6 / 64'd2) / 64'd6,
		(TWO63 + 64'd7 / 64'd2) / 64'd7,
		(TWO63 + 64'd8 / 64'd2) / 64'd8,
		(TWO63 + 64'd9 / 64'd2) / 64'd9,
		(TWO63 + 64'd10 / 64'd2) / 64'd10,
		(TWO63 + 64'd11 / 64'd2) / 64'd11,
		(TWO63 + 64'd12 / 64'd2) / 64'd12,
		(TWO63 + 64'd13 / 64'd2) / 64'd13,
		(TWO63 + 64'd14 / 64'd2) / 64'd14,
		(TWO63 + 64'd15 / 64'd2) / 64'd15,
		(TWO63 + 64'd16 / 64'd2) / 64'd16,
		(TWO63 + 64'd17 / 64'd2) / 64'd17,
		(TWO63 + 64'd18 / 64'd2) / 64'd18,
		(TWO63 + 64'd19 / 64'd2) / 64'd19,
		(TWO63 + 64'd20 / 64'd2) / 64'd20,
		(TWO63 + 64'd21 / 64'd2) / 64'd21,
		(TWO63 + 64'd22 / 64'd2) / 64'd22,
		(TWO63 + 64'd23 / 64'd2) / 64'd23,
		(TWO63 + 64'd24 / 64'd2) / 64'd24,
		(TWO63 + 64'd25 / 64'd2) / 64'd25,
		(TWO63 + 64'd26 / 64'd2) / 64'd26,
		(TWO63 + 64'd27 / 64'd2) / 64'd27,
		(TWO63 + 64'd28 / 64'd2) / 64'd28,
		(TWO63 + 64'd29 / 64'd2) / 64'd29,
		(TWO63 + 64'd30 / 64'd2) / 64'd30,
		(TWO63 + 64'd31 / 64'd2) / 64'd31
	};

	// sequencer step addresses
	typedef enum logic [3:0] {
		ST_WAIT,
		ST_CHK,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_T0,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_T4,
		ST_T5,
		ST_NEXT,
		ST_FIN
	} step_t;

	// multiplier operand selects
	typedef enum logic {
		A_LO,
		A_HI
	} mul_a_t;

	typedef enum logic [1:0] {
		B_X,
		B_CLO,
		B_CHI
	} mul_b_t;

	// product register operations
	typedef enum logic [2:0] {
		PR_HOLD,
		PR_LD_HF,
		PR_LD_H63,
		PR_ADD32,
		PR_ADD64
	} pr_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_START,
		C_INVAL,
		C_NOUSE,
		C_LAST,
		C_OUT_FREE
	} cond_t;

	// datapath part of a control word
	typedef struct packed {
		mul_a_t mul_a;
		mul_b_t mul_b;
		pr_op_t pr_op;
		logic   ld_in;
		logic   wr_pmag;
		logic   add_term;
		logic   inc_n;
		logic   ld_out;
	} dp_ctrl_t;

	// full control word
	typedef struct packed {
		dp_ctrl_t dp;
		cond_t    cond;
		step_t    tgt_t;
		step_t    tgt_f;
	} ucode_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic start;
		logic inval;
		logic nouse;
		logic last;
		logic out_free;
	} seq_flags_t;

	// saturate a shifted product to the magnitude limit
	function automatic logic [62:0] sat_mag(input logic [127:0] v);
		return (v > {65'd0, MAG_LIMIT}) ? MAG_LIMIT : v[62:0];
	endfunction

endpackage

// ===== rtl/tsfe_in_if.sv =====
interface tsfe_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	logic signed [31:0] arg;

	modport source (output valid, output cmd, output arg, input ready);
	modport sink (input valid, input cmd, input arg, output ready);
endinterface

// ===== rtl/tsfe_out_if.sv =====
interface tsfe_out_if;
	logic              valid;
	logic              ready;
	logic signed [39:0] value;
	logic              invalid;
	logic              overflow;

	modport source (output valid, output value, output invalid, output overflow, input ready);
	modport sink (input valid, input value, input invalid, input overflow, output ready);
endinterface

// ===== rtl/tsfe_seq.sv =====
module tsfe_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsfe_pkg::seq_flags_t  flags,
	output tsfe_pkg::dp_ctrl_t    dp
);
	import tsfe_pkg::*;

	step_t  step_q;
	step_t  step_d;
	ucode_t word_nx;
	ucode_t word_out;
	logic   take;

	// microprogram, one control word per step
	function automatic ucode_t ucode(input step_t s);
		ucode_t w;
		w = '0;
		unique case (s)
			ST_WAIT: begin
				w.dp.ld_in = 1'b1;
				w.cond = C_START;
				w.tgt_t = ST_CHK;
				w.tgt_f = ST_WAIT;
			end
			ST_CHK: begin
				w.cond = C_INVAL;
				w.tgt_t = ST_FIN;
				w.tgt_f = ST_T0;
			end
			ST_P0: begin
				w.dp.mul_a = A_LO;
				w.dp.mul_b = B_X;
				w.tgt_t = ST_P1;
			end
			ST_P1: begin
				w.dp.mul_a = A_HI;
				w.dp.mul_b = B_X;
				w.dp.pr_op = PR_LD_HF;
				w.tgt_t = ST_P2;
			end
			ST_P2: begin
				w.dp.pr_op = PR_ADD32;
				w.tgt_t = ST_P3;
			end
			ST_P3: begin
				w.dp.wr_pmag = 1'b1;
				w.tgt_t = ST_T0;
			end
			ST_T0: begin
				w.dp.mul_a = A_LO;
				w.dp.mul_b = B_CLO;
				w.cond = C_NOUSE;
				w.tgt_t = ST_NEXT;
				w.tgt_f = ST_T1;
			end
			ST_T1: begin
				w.dp.mul_a = A_LO;
				w.dp.mul_b = B_CHI;
				w.dp.pr_op = PR_LD_H63;
				w.tgt_t = ST_T2;
			end
			ST_T2: begin
				w.dp.mul_a = A_HI;
				w.dp.mul_b = B_CLO;
				w.dp.pr_op = PR_ADD32;
				w.tgt_t = ST_T3;
			end
			ST_T3: begin
				w.dp.mul_a = A_HI;
				w.dp.mul_b = B_CHI;
				w.dp.pr_op = PR_ADD32;
				w.tgt_t = ST_T4;
			end
			ST_T4: begin
				w.dp.pr_op = PR_ADD64;
				w.tgt_t = ST_T5;
			end
			ST_T5: begin
				w.dp.add_term = 1'b1;
				w.dp.inc_n = 1'b1;
				w.cond = C_LAST;
				w.tgt_t = ST_FIN;
				w.tgt_f = ST_P0;
			end
			ST_NEXT: begin
				w.dp.inc_n = 1'b1;
				w.cond = C_LAST;
				w.tgt_t = ST_FIN;
				w.tgt_f = ST_P0;
			end
			ST_FIN: begin
				w.dp.ld_out = 1'b1;
				w.cond = C_OUT_FREE;
				w.tgt_t = ST_WAIT;
				w.tgt_f = ST_FIN;
			end
			default: begin
				w.tgt_t = ST_WAIT;
			end
		endcase
		return w;
	endfunction

	// next step: evaluate the jump condition
	always_comb begin
		word_nx = ucode(step_q);
		unique case (word_nx.cond)
			C_ALWAYS:   take = 1'b1;
			C_START:    take = flags.start;
			C_INVAL:    take = flags.inval;
			C_NOUSE:    take = flags.nouse;
			C_LAST:     take = flags.last;
			C_OUT_FREE: take = flags.out_free;
			default:    take = 1'b1;
		endcase
		step_d = take ? word_nx.tgt_t : word_nx.tgt_f;
	end

	// datapath controls for the current step
	always_comb begin
		word_out = ucode(step_q);
		dp = word_out.dp;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== rtl/truncated_series_function_eval_core.sv =====
// channel   dir   payload                          transaction when
// in_ch     in    cmd[2:0], arg[31:0] Q2.29        valid && ready
// out_ch    out   value[39:0] Q10.29, invalid,     valid && ready
//                 overflow
// apb       in    max_power at paddr 0             psel && penable && pwrite
//
// one item at a time; a 32x32 multiplier is shared by all products, so a power
// costs less when its term is skipped than when it is used (power zero needs no
// power product). latency from acceptance to result grows with the per-power
// costs up to max_power; an invalid selector or log1p domain error skips them.
// arst_n clears the sequencer, the output valid and max_power (to 7).
// the result sits in an output register; the next item is taken while it waits,
// and the sequencer only holds in its last step if that register is still full.
module truncated_series_function_eval_core #(
	parameter int unsigned MAX_POWER = 15,
	parameter int unsigned FRAC_BITS = 29
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tsfe_in_if.sink                       in_ch,
	tsfe_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsfe_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tsfe_pkg::*;

	localparam int unsigned NW = $clog2(MAX_POWER + 1);
	localparam logic [62:0] ONE_FX = 63'(1) << FRAC_BITS;
	localparam logic [127:0] HALF_F = 128'(1) << (FRAC_BITS - 1);
	localparam logic [127:0] HALF_63 = 128'(1) << 62;
	localparam logic signed [63:0] ACC_MAX = {1'b0, MAG_LIMIT};

	dp_ctrl_t   dp;
	seq_flags_t flags;

	logic [3:0]   max_power_q;
	logic [2:0]   cmd_q;
	logic [31:0]  xmag_q;
	logic         xneg_q;
	logic         inval_q;
	logic [NW-1:0] k_q;
	logic [NW-1:0] n_q;
	logic [62:0]  pmag_q;
	logic [63:0]  pp_q;
	logic [127:0] prod_q;
	logic [127:0] prod_d;
	logic signed [63:0] acc_q;
	logic signed [63:0] acc_d;
	logic signed [64:0] acc_sum;

	logic         out_valid_q;
	logic signed [39:0] out_value_q;
	logic         out_invalid_q;
	logic         out_ovf_q;

	logic         in_acc;
	logic         out_free;
	logic         out_load;
	logic [31:0]  raw;
	logic [31:0]  xmag_in;
	logic         inval_in;
	logic [NW-1:0] k_in;
	logic [4:0]   nidx;
	logic [63:0]  coef;
	logic [31:0]  mul_a_op;
	logic [31:0]  mul_b_op;
	logic         use_term;
	logic         neg_term;
	logic         sub_term;
	logic [62:0]  term_mag;
	logic signed [39:0] res_value;
	logic         res_ovf;

	// sequencer
	tsfe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.dp     (dp)
	);

	// handshakes
	assign in_acc   = in_ch.valid && dp.ld_in;
	assign out_free = !out_valid_q || out_ch.ready;
	assign out_load = dp.ld_out && out_free;
	assign in_ch.ready = dp.ld_in;

	// argument magnitude and domain check
	always_comb begin
		raw = in_ch.arg;
		xmag_in = raw[31] ? (~raw + 32'd1) : raw;
		inval_in = (in_ch.cmd > CMD_ATAN) ||
			((in_ch.cmd == CMD_LOG1P) && ({31'd0, xmag_in} >= ONE_FX));
		if ({1'b0, max_power_q} > 5'(MAX_POWER)) begin
			k_in = NW'(MAX_POWER);
		end else begin
			k_in = NW'(max_power_q);
		end
	end

	// term selection and sign per function
	assign nidx = 5'(n_q);
	always_comb begin
		case (cmd_q) inside
			CMD_SIN, CMD_ATAN: begin
				use_term = nidx[0];
				neg_term = (nidx[1:0] == 2'b11);
			end
			CMD_COS: begin
				use_term = !nidx[0];
				neg_term = (nidx[1:0] == 2'b10);
			end
			CMD_EXP: begin
				use_term = 1'b1;
				neg_term = 1'b0;
			end
			CMD_LOG1P: begin
				use_term = (nidx != 5'd0);
				neg_term = !nidx[0];
			end
			default: begin
				use_term = 1'b0;
				neg_term = 1'b0;
			end
		endcase
		sub_term = neg_term ^ (xneg_q & nidx[0]);
		coef = (cmd_q <= CMD_EXP) ? INV_FACT[nidx] : RECIP_N[nidx];
	end

	// shared multiplier operands
	always_comb begin
		mul_a_op = (dp.mul_a == A_HI) ? {1'b0, pmag_q[62:32]} : pmag_q[31:0];
		case (dp.mul_b)
			B_CLO:   mul_b_op = coef[31:0];
			B_CHI:   mul_b_op = coef[63:32];
			default: mul_b_op = xmag_q;
		endcase
	end

	// product accumulation, rounding half seeded at load
	always_comb begin
		case (dp.pr_op)
			PR_LD_HF:  prod_d = HALF_F + {64'd0, pp_q};
			PR_LD_H63: prod_d = HALF_63 + {64'd0, pp_q};
			PR_ADD32:  prod_d = prod_q + ({64'd0, pp_q} << 32);
			PR_ADD64:  prod_d = prod_q + ({64'd0, pp_q} << 64);
			default:   prod_d = prod_q;
		endcase
	end

	// term add with saturation of the running sum
	always_comb begin
		term_mag = sat_mag(prod_q >> 63);
		if (sub_term) begin
			acc_sum = $signed({acc_q[63], acc_q}) - $signed({2'b00, term_mag});
		end else begin
			acc_sum = $signed({acc_q[63], acc_q}) + $signed({2'b00, term_mag});
		end
		if (acc_sum > ACC_LIM_P) begin
			acc_d = 64'(ACC_LIM_P);
		end else if (acc_sum < ACC_LIM_N) begin
			acc_d = 64'(ACC_LIM_N);
		end else begin
			acc_d = 64'(acc_sum);
		end
	end

	// final clamp to the output range
	always_comb begin
		res_ovf = 1'b0;
		if (inval_q) begin
			res_value = '0;
		end else if (acc_q > OUT_MAX) begin
			res_value = 40'(OUT_MAX);
			res_ovf = 1'b1;
		end else if (acc_q < OUT_MIN) begin
			res_value = 40'(OUT_MIN);
			res_ovf = 1'b1;
		end else begin
			res_value = acc_q[39:0];
		end
	end

	// status to the sequencer
	always_comb begin
		flags.start    = in_ch.valid;
		flags.inval    = inval_q;
		flags.nouse    = !use_term;
		flags.last     = (n_q == k_q);
		flags.out_free = out_free;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pp_q <= 64'(mul_a_op) * 64'(mul_b_op);
		prod_q <= prod_d;
		if (in_acc) begin
			cmd_q <= in_ch.cmd;
			xmag_q <= xmag_in;
			xneg_q <= raw[31];
			inval_q <= inval_in;
			k_q <= k_in;
			n_q <= '0;
			pmag_q <= ONE_FX;
			acc_q <= '0;
		end else begin
			if (dp.inc_n) begin
				n_q <= n_q + NW'(1);
			end
			if (dp.wr_pmag) begin
				pmag_q <= sat_mag(prod_q >> FRAC_BITS);
			end
			if (dp.add_term) begin
				acc_q <= acc_d;
			end
		end
		if (out_load) begin
			out_value_q <= res_value;
			out_invalid_q <= inval_q;
			out_ovf_q <= res_ovf;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.value    = out_value_q;
	assign out_ch.invalid  = out_invalid_q;
	assign out_ch.overflow = out_ovf_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_power_q <= MAX_POWER_RST;
		end else if (psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_MAX_POWER)) begin
			max_power_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[APB_AW-1:2] == REG_MAX_POWER) ? {28'd0, max_power_q} : 32'd0;
	assign pready = 1'b1;

`ifndef SYNTHESIS
	a_bad_cmd_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_ch.cmd > CMD_ATAN)) |=> inval_q)
		else $error("unknown selector not flagged invalid");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.invalid) |-> ((out_ch.value == '0) && !out_ch.overflow))
		else $error("invalid result carries a value or overflow");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp.add_term |-> ((acc_q <= ACC_MAX) && (acc_q >= -ACC_MAX)))
		else $error("running sum outside saturation bound");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !dp.ld_in)
		else $error("sequencer took a second item while busy");
`endif

endmodule
